// File: rtl/mcps_pkg.sv
// mcps_pkg: word types, port codes and midi constants for the sysex translator
// no dependencies; imported by every module of the block
package mcps_pkg;

	// burst buffer depth: longest parameter-change message
	localparam int MaxWords = 9;
	localparam int CntW     = $clog2(MaxWords + 1);

	typedef logic [CntW-1:0] cnt_t;

	typedef struct packed {
		logic       op;
		logic [3:0] port_offset;
		logic [7:0] write_data;
	} in_word_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] value;
		logic       last;
	} out_word_t;

	// words caused by one access, emitted from bytes[0] upward
	typedef struct packed {
		cnt_t                       count;
		logic                       kind;
		logic [MaxWords-1:0][7:0]   bytes;
	} burst_t;

	// access kinds
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// result kinds
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_MIDI = 1'b1;

	// port offsets
	localparam logic [3:0] PORT_DATA   = 4'd1;
	localparam logic [3:0] PORT_STATUS = 4'd2;
	localparam logic [3:0] PORT_CTRL_LO = 4'd8;
	localparam logic [3:0] PORT_CTRL_HI = 4'd11;

	localparam logic [7:0] STATUS_VAL = 8'h15;
	localparam logic [7:0] MODE_ON    = 8'h00;
	localparam logic [7:0] MODE_OFF   = 8'h10;

	// midi bytes
	localparam logic [7:0] SYX_START  = 8'hF0;
	localparam logic [7:0] SYX_END    = 8'hF7;
	localparam logic [7:0] HDR_MAKER  = 8'h43;
	localparam logic [7:0] HDR_GROUP  = 8'h75;
	localparam logic [7:0] HDR_LIST   = 8'h71;
	localparam logic [7:0] PARAM_CHG  = 8'h18;
	localparam logic [7:0] FOUR_FLAG  = 8'h40;
	localparam logic [7:0] PARAM_MASK = 8'h3F;

	// expected parameter-list header, one byte per match step
	function automatic logic [7:0] hdr_byte(input logic [1:0] k);
		logic [7:0] r;
		case (k)
			2'd0:    r = SYX_START;
			2'd1:    r = HDR_MAKER;
			2'd2:    r = HDR_GROUP;
			2'd3:    r = HDR_LIST;
			default: r = SYX_START;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/mcps_filter.sv
// mcps_filter: port decode, mode/data registers and sysex translation state
// depends on mcps_pkg; builds the burst of result words for one access
module mcps_filter
	import mcps_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  in_word_t item,
	output burst_t   desc
);

	logic             data_mode_q, data_mode_d;
	logic [7:0]       last_byte_q, last_byte_d;
	logic             in_sysex_q, in_sysex_d;
	logic             translating_q, translating_d;
	logic [2:0]       hdr_cnt_q, hdr_cnt_d;
	logic [1:0]       param_cnt_q, param_cnt_d;
	logic [2:0][7:0]  param_q;
	logic             param_we;
	logic [1:0]       param_idx;

	function automatic burst_t build_change(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic four, input logic [7:0] d4);
		burst_t     r;
		logic [7:0] p;
		r        = '0;
		p        = b1 & PARAM_MASK;
		r.kind   = KIND_MIDI;
		r.bytes[0] = SYX_START;
		r.bytes[1] = HDR_MAKER;
		r.bytes[2] = HDR_GROUP;
		r.bytes[3] = {4'h0, b0[3:0]};
		r.bytes[4] = PARAM_CHG | {5'd0, b0[6:4]};
		r.bytes[6] = b2;
		if (four) begin
			r.bytes[5] = p | FOUR_FLAG;
			r.bytes[7] = d4;
			r.bytes[8] = SYX_END;
			r.count    = cnt_t'(9);
		end else begin
			r.bytes[5] = p;
			r.bytes[7] = SYX_END;
			r.count    = cnt_t'(8);
		end
		return r;
	endfunction

	always_comb begin
		logic       start;
		logic       insx;
		logic [2:0] hm;
		logic       tr;
		logic [1:0] pc;
		logic [7:0] d;

		d             = item.write_data;
		start         = (d == SYX_START);
		insx          = start | in_sysex_q;
		hm            = start ? 3'd0 : hdr_cnt_q;
		tr            = start ? 1'b0 : translating_q;
		pc            = start ? 2'd0 : param_cnt_q;

		desc          = '0;
		data_mode_d   = data_mode_q;
		last_byte_d   = last_byte_q;
		in_sysex_d    = in_sysex_q;
		translating_d = translating_q;
		hdr_cnt_d     = hdr_cnt_q;
		param_cnt_d   = param_cnt_q;
		param_we      = 1'b0;
		param_idx     = pc;

		if (item.op == OP_READ) begin
			desc.count = cnt_t'(1);
			desc.kind  = KIND_READ;
			if (item.port_offset == PORT_DATA)
				desc.bytes[0] = last_byte_q;
			else if (item.port_offset == PORT_STATUS)
				desc.bytes[0] = STATUS_VAL;
		end else if (item.port_offset == PORT_DATA) begin
			last_byte_d = d;
			if (data_mode_q) begin
				in_sysex_d    = insx;
				hdr_cnt_d     = hm;
				translating_d = tr;
				param_cnt_d   = pc;
				if (!insx) begin
					// plain midi passes through
					desc.count    = cnt_t'(1);
					desc.kind     = KIND_MIDI;
					desc.bytes[0] = d;
				end else if (hm < 3'd4) begin
					if (hdr_byte(hm[1:0]) == d) begin
						hdr_cnt_d = hm + 3'd1;
						if (hm == 3'd3)
							translating_d = 1'b1;
					end else begin
						// header mismatch: flush matched bytes, then this one
						in_sysex_d    = 1'b0;
						translating_d = 1'b0;
						desc.count    = cnt_t'(hm + 3'd1);
						desc.kind     = KIND_MIDI;
						for (int k = 0; k < 5; k++) begin
							if (3'(k) < hm)
								desc.bytes[k] = hdr_byte(2'(k));
							else if (3'(k) == hm)
								desc.bytes[k] = d;
						end
					end
				end else if (!tr) begin
					// stray sysex dropped
				end else if (d == SYX_END) begin
					in_sysex_d    = 1'b0;
					translating_d = 1'b0;
					param_cnt_d   = 2'd0;
				end else if (pc == 2'd3) begin
					desc        = build_change(param_q[0], param_q[1], param_q[2], 1'b1, d);
					param_cnt_d = 2'd0;
				end else begin
					param_we    = 1'b1;
					param_cnt_d = pc + 2'd1;
					if (pc == 2'd2 && !param_q[1][6]) begin
						desc        = build_change(param_q[0], param_q[1], d, 1'b0, 8'h00);
						param_cnt_d = 2'd0;
					end
				end
			end
		end else if (item.port_offset inside {[PORT_CTRL_LO:PORT_CTRL_HI]}) begin
			if (d == MODE_ON)
				data_mode_d = 1'b1;
			else if (d == MODE_OFF)
				data_mode_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_mode_q   <= 1'b1;
			last_byte_q   <= 8'h00;
			in_sysex_q    <= 1'b0;
			translating_q <= 1'b0;
			hdr_cnt_q     <= 3'd0;
			param_cnt_q   <= 2'd0;
		end else if (fire) begin
			data_mode_q   <= data_mode_d;
			last_byte_q   <= last_byte_d;
			in_sysex_q    <= in_sysex_d;
			translating_q <= translating_d;
			hdr_cnt_q     <= hdr_cnt_d;
			param_cnt_q   <= param_cnt_d;
		end
	end

	// parameter entry bytes, only read after being written
	always_ff @(posedge clk) begin
		if (fire && param_we)
			param_q[param_idx] <= item.write_data;
	end

endmodule

// File: rtl/mcps_burst.sv
// mcps_burst: result register that shifts out a burst one word per handshake
// depends on mcps_pkg; loads a burst_t from mcps_filter
module mcps_burst
	import mcps_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_ready,
	input  burst_t    desc,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	cnt_t                     rem_q;
	logic                     kind_q;
	logic [MaxWords-1:0][7:0] bytes_q;
	logic                     load;
	logic                     take;

	assign out_valid = (rem_q != '0);
	assign take      = out_valid && out_ready;
	// free, or the final word leaves this cycle
	assign src_ready = (rem_q == '0) || (rem_q == cnt_t'(1) && out_ready);
	assign load      = src_valid && src_ready;

	assign out_data.kind  = kind_q;
	assign out_data.value = bytes_q[0];
	assign out_data.last  = (rem_q == cnt_t'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= desc.count;
		end else if (take) begin
			rem_q <= rem_q - cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= desc.kind;
			bytes_q <= desc.bytes;
		end else if (take) begin
			bytes_q <= {8'h00, bytes_q[MaxWords-1:1]};
		end
	end

endmodule

// File: rtl/music_card_port_sysex_translator.sv
// path: an accepted word is held in the input register, and its result words are loaded into the
//   result register once that register can take them; the first result word is shown from there
//   (a busy result register keeps the word waiting in the input register)
// throughput: one input word per cycle when each causes at most one result and the output is
//   not stalled; an access causing several result words (up to 9) holds the input until the single
//   word-wide result register has shifted its burst out one word per handshake
// reset: arst_n clears all control state; data mode comes up on, no result pending
module music_card_port_sysex_translator
	import mcps_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	// input register
	logic     valid_s1;
	in_word_t item_s1;

	// handshake into the burst register
	logic   burst_ready;
	logic   fire;
	burst_t desc;

	// the input word is processed when the burst register can take its results
	assign fire     = valid_s1 && burst_ready;
	// input register frees up in the same cycle its word moves on
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
	end

	// decode and sysex translation, state advances when the word is consumed
	mcps_filter u_filter (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.desc   (desc)
	);

	// result register, bursts of 0..9 words; a zero-word burst just passes
	mcps_burst u_burst (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (valid_s1),
		.src_ready (burst_ready),
		.desc      (desc),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: rtl/mcps_checker.sv
// mcps_checker: port-level assertions for the sysex translator
// depends on mcps_pkg; bound to music_card_port_sysex_translator
module mcps_checker
	import mcps_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_word_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	// offered input word holds until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input word changed while waiting");

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// a read gives exactly one word
	a_read_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_READ |-> out_data.last)
		else $error("read result not marked last");

	// a multi-word midi burst continues without gaps
	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |=> out_valid && out_data.kind == KIND_MIDI)
		else $error("midi burst broken");

	// with no result pending the input side is never blocked
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind music_card_port_sysex_translator mcps_checker u_chk (.*);
